/* hw/rtl/fsrd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fsrd_pkg;

    // Receive store size and the count width that follows from it
    localparam int BUF_BYTES = 64;
    localparam int CNT_W     = $clog2(BUF_BYTES);

    // Configuration register indexes
    localparam logic [2:0] REG_START_CHAR  = 3'd0;
    localparam logic [2:0] REG_END_CHAR    = 3'd1;
    localparam logic [2:0] REG_ESCAPE_CHAR = 3'd2;
    localparam logic [2:0] REG_CODE_START  = 3'd3;
    localparam logic [2:0] REG_CODE_END    = 3'd4;
    localparam logic [2:0] REG_CODE_ESCAPE = 3'd5;
    localparam logic [2:0] REG_FRAME_LIMIT = 3'd6;

    // Register reset values
    localparam logic [7:0] RST_START_CHAR  = 8'd33;
    localparam logic [7:0] RST_END_CHAR    = 8'd59;
    localparam logic [7:0] RST_ESCAPE_CHAR = 8'd92;
    localparam logic [7:0] RST_CODE_START  = 8'd49;
    localparam logic [7:0] RST_CODE_END    = 8'd50;
    localparam logic [7:0] RST_CODE_ESCAPE = 8'd51;
    localparam logic [6:0] RST_FRAME_LIMIT = 7'd64;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [7:0]       start_char;
        logic [7:0]       end_char;
        logic [7:0]       escape_char;
        logic [7:0]       code_start;
        logic [7:0]       code_end;
        logic [7:0]       code_escape;
        logic [CNT_W-1:0] limit_m1;     // clamped limit minus one
    } cfg_t;

    // Shared compare unit result
    typedef struct packed {
        logic eq;
        logic ge;
    } cmp_res_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LIMIT,
        ST_ENDCHK,
        ST_SUMCHK,
        ST_ESCCHK,
        ST_CODE_S,
        ST_CODE_E,
        ST_CODE_X,
        ST_STORE,
        ST_DRAIN_RD,
        ST_DRAIN_LD
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/fsrd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fsrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/fsrd_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none

module fsrd_cmp
    import fsrd_pkg::*;
(
    input  wire logic [7:0] a,
    input  wire logic [7:0] b,
    output cmp_res_t        res
);

    // Equality and unsigned magnitude on one pair of operands
    always_comb begin
        res.eq = (a == b);
        res.ge = (a >= b);
    end

endmodule

`default_nettype wire

/* hw/rtl/fsrd_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module fsrd_cfg
    import fsrd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output cfg_t            cfg
);

    logic [7:0] start_reg,  start_next;
    logic [7:0] end_reg,    end_next;
    logic [7:0] esc_reg,    esc_next;
    logic [7:0] cstart_reg, cstart_next;
    logic [7:0] cend_reg,   cend_next;
    logic [7:0] cesc_reg,   cesc_next;
    logic [6:0] limit_reg,  limit_next;
    logic [8:0] lim_w;

    assign cfg_ready = 1'b1;

    // Register write decode; unknown indexes are dropped
    always_comb begin
        start_next  = start_reg;
        end_next    = end_reg;
        esc_next    = esc_reg;
        cstart_next = cstart_reg;
        cend_next   = cend_reg;
        cesc_next   = cesc_reg;
        limit_next  = limit_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_CHAR:  start_next  = cfg_data;
                REG_END_CHAR:    end_next    = cfg_data;
                REG_ESCAPE_CHAR: esc_next    = cfg_data;
                REG_CODE_START:  cstart_next = cfg_data;
                REG_CODE_END:    cend_next   = cfg_data;
                REG_CODE_ESCAPE: cesc_next   = cfg_data;
                REG_FRAME_LIMIT: limit_next  = cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= RST_START_CHAR;
            end_reg    <= RST_END_CHAR;
            esc_reg    <= RST_ESCAPE_CHAR;
            cstart_reg <= RST_CODE_START;
            cend_reg   <= RST_CODE_END;
            cesc_reg   <= RST_CODE_ESCAPE;
            limit_reg  <= RST_FRAME_LIMIT;
        end else begin
            start_reg  <= start_next;
            end_reg    <= end_next;
            esc_reg    <= esc_next;
            cstart_reg <= cstart_next;
            cend_reg   <= cend_next;
            cesc_reg   <= cesc_next;
            limit_reg  <= limit_next;
        end
    end

    // Clamp the frame limit to 2..store size
    always_comb begin
        priority if ({2'b00, limit_reg} < 9'd2) begin
            lim_w = 9'd2;
        end else if ({2'b00, limit_reg} > 9'(BUF_BYTES)) begin
            lim_w = 9'(BUF_BYTES);
        end else begin
            lim_w = {2'b00, limit_reg};
        end
    end

    always_comb begin
        cfg.start_char  = start_reg;
        cfg.end_char    = end_reg;
        cfg.escape_char = esc_reg;
        cfg.code_start  = cstart_reg;
        cfg.code_end    = cend_reg;
        cfg.code_escape = cesc_reg;
        cfg.limit_m1    = CNT_W'(lim_w - 9'd1);
    end

endmodule

`default_nettype wire

/* hw/rtl/framed_serial_rx_deframer_top.sv */
// Receive deframer for a byte-stuffed serial link with an 8-bit sum checksum.
// Input channel s_*: one raw received byte per word. Output channel m_*: one
// unescaped body byte per word, m_tlast on the final byte of a frame.
// Configuration channel cfg_*: cfg_index selects the register (start, end,
// escape, three escape codes, frame limit), cfg_data is the value; always
// ready, to be written only while no frame output is pending.
// Sequencing: each received byte runs through a sequencer that uses one
// shared 8-bit compare unit per step: start check; inside a frame the limit
// and end checks, then the sum check for a checksum byte or else the escape
// check, the three escape codes in turn after an escape byte, and storing.
// After a good checksum the body is read back from the store through the
// single registered read port, a read and a load step per byte. Input is not
// accepted during the read-back. The output word sits in a register: a
// stalled receiver holds the read-back, and once the last word is loaded the
// next input is accepted while that word still waits.
// Reset: registers return to their defaults, no frame is open, the output
// is empty. The body store is not cleared; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module framed_serial_rx_deframer_top
    import fsrd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // raw byte in
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] rx_byte
    // body bytes out
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,    // [7:0] body_byte
    output logic            m_tlast,    // last_of_body
    // register writes
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    state_t           state_reg, state_next;
    logic [7:0]       byte_reg, byte_next;
    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] raw_count_reg, raw_count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       prev_reg, prev_next;
    logic [CNT_W-1:0] body_count_reg, body_count_next;
    logic [CNT_W-1:0] drain_idx_reg, drain_idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;

    cfg_t             cfg;
    cmp_res_t         cmp_res;
    logic [7:0]       cmp_a, cmp_b;
    logic             ram_we;
    logic [CNT_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;
    logic             out_free;
    logic             out_load;
    logic             drain_last;

    fsrd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fsrd_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    fsrd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (drain_idx_reg),
        .rdata (ram_rdata)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign out_free   = !m_valid_reg || m_tready;
    assign drain_last = (drain_idx_reg == body_count_reg - CNT_W'(2));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (cmp_res.eq || !in_frame_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT: state_next = cmp_res.ge ? ST_IDLE : ST_ENDCHK;
            ST_ENDCHK: state_next = cmp_res.eq ? ST_SUMCHK : ST_ESCCHK;
            ST_SUMCHK: begin
                if (cmp_res.eq && (body_count_reg >= CNT_W'(2))) begin
                    state_next = ST_DRAIN_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ESCCHK: begin
                if (cmp_res.eq && (body_count_reg != '0)) begin
                    state_next = ST_CODE_S;
                end else begin
                    state_next = ST_STORE;
                end
            end
            ST_CODE_S: state_next = cmp_res.eq ? ST_IDLE : ST_CODE_E;
            ST_CODE_E: state_next = cmp_res.eq ? ST_IDLE : ST_CODE_X;
            ST_CODE_X: state_next = cmp_res.eq ? ST_IDLE : ST_STORE;
            ST_STORE: state_next = ST_IDLE;
            ST_DRAIN_RD: state_next = ST_DRAIN_LD;
            ST_DRAIN_LD: begin
                if (out_free) begin
                    state_next = drain_last ? ST_IDLE : ST_DRAIN_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Per-step operand selection and frame state updates
    always_comb begin
        byte_next       = byte_reg;
        in_frame_next   = in_frame_reg;
        raw_count_next  = raw_count_reg;
        sum_next        = sum_reg;
        prev_next       = prev_reg;
        body_count_next = body_count_reg;
        drain_idx_next  = drain_idx_reg;
        cmp_a           = byte_reg;
        cmp_b           = cfg.start_char;
        ram_we          = 1'b0;
        ram_waddr       = body_count_reg;
        ram_wdata       = byte_reg;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    byte_next = s_tdata;
                end
            end
            ST_START: begin
                // start byte always opens a fresh frame
                if (cmp_res.eq) begin
                    in_frame_next   = 1'b1;
                    raw_count_next  = CNT_W'(1);
                    sum_next        = byte_reg;
                    prev_next       = byte_reg;
                    body_count_next = '0;
                end else if (in_frame_reg) begin
                    raw_count_next = raw_count_reg + CNT_W'(1);
                end
            end
            ST_LIMIT: begin
                cmp_a = 8'(raw_count_reg);
                cmp_b = 8'(cfg.limit_m1);
                if (cmp_res.ge) begin
                    in_frame_next = 1'b0;
                end
            end
            ST_ENDCHK: begin
                cmp_a = prev_reg;
                cmp_b = cfg.end_char;
            end
            ST_SUMCHK: begin
                // checksum byte closes the frame whatever its value
                cmp_a          = sum_reg;
                cmp_b          = byte_reg;
                in_frame_next  = 1'b0;
                drain_idx_next = '0;
            end
            ST_ESCCHK: begin
                cmp_a     = prev_reg;
                cmp_b     = cfg.escape_char;
                sum_next  = sum_reg + byte_reg;
                prev_next = byte_reg;
            end
            ST_CODE_S: begin
                cmp_b     = cfg.code_start;
                ram_we    = cmp_res.eq;
                ram_waddr = body_count_reg - CNT_W'(1);
                ram_wdata = cfg.start_char;
            end
            ST_CODE_E: begin
                cmp_b     = cfg.code_end;
                ram_we    = cmp_res.eq;
                ram_waddr = body_count_reg - CNT_W'(1);
                ram_wdata = cfg.end_char;
            end
            ST_CODE_X: begin
                cmp_b     = cfg.code_escape;
                ram_we    = cmp_res.eq;
                ram_waddr = body_count_reg - CNT_W'(1);
                ram_wdata = cfg.escape_char;
            end
            ST_STORE: begin
                ram_we          = 1'b1;
                body_count_next = body_count_reg + CNT_W'(1);
            end
            ST_DRAIN_RD: ;
            ST_DRAIN_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (!drain_last) begin
                        drain_idx_next = drain_idx_reg + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Output word register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = ram_rdata;
            m_last_next  = drain_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_frame_reg   <= 1'b0;
            raw_count_reg  <= '0;
            sum_reg        <= '0;
            prev_reg       <= '0;
            body_count_reg <= '0;
            drain_idx_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            in_frame_reg   <= in_frame_next;
            raw_count_reg  <= raw_count_next;
            sum_reg        <= sum_next;
            prev_reg       <= prev_next;
            body_count_reg <= body_count_next;
            drain_idx_reg  <= drain_idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

`ifndef SYNTHESIS
    // read-back only runs with the frame closed
    a_drain_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN_RD || state_reg == ST_DRAIN_LD) |-> !in_frame_reg)
        else $error("read-back with a frame open");

    // stored body never outgrows the raw byte count of the open frame
    a_body_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && in_frame_reg) |-> (body_count_reg < raw_count_reg))
        else $error("body count not below raw count");

    // store is never written during read-back
    a_no_write_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !(state_reg == ST_DRAIN_RD || state_reg == ST_DRAIN_LD))
        else $error("store write during read-back");

    // loading the final word ends the read-back
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && drain_last) |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("final word did not end read-back");

    // a word is only loaded over an empty or departing output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("output word overwritten");
`endif

endmodule

`default_nettype wire
